FILE: design/afr_pkg.sv
package afr_pkg;

  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_LEN_HI = 3'd1,
    ST_LEN_LO = 3'd2,
    ST_DATA   = 3'd3,
    ST_CHECK  = 3'd4,
    ST_RESYNC = 3'd5
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] KEEP_MARK  = 8'd129;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

endpackage

FILE: design/afr_parser.sv
module afr_parser #(
  parameter int MAX_LEN = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             chunk_last,
  output logic             res_valid,
  output afr_pkg::result_t res
);
  import afr_pkg::*;

  localparam logic [15:0] MAX_LEN_W = 16'(MAX_LEN);

  parse_state_t state_r, state_nxt;
  logic [15:0]  frame_length_r, frame_length_nxt;
  logic [15:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]   running_sum_r, running_sum_nxt;
  logic         keep_payload_r, keep_payload_nxt;

  logic [15:0]  lo_len;
  logic [15:0]  seen_inc;
  logic         keep_eff;
  logic         sum_ok;

  assign lo_len   = {frame_length_r[7:0], rx_byte};
  assign seen_inc = bytes_seen_r + 16'd1;
  assign keep_eff = (bytes_seen_r == 16'd0) ? (rx_byte == KEEP_MARK) : keep_payload_r;
  assign sum_ok   = (rx_byte == ~running_sum_r);

  // next state and frame bookkeeping
  always_comb begin
    state_nxt        = state_r;
    frame_length_nxt = frame_length_r;
    bytes_seen_nxt   = bytes_seen_r;
    running_sum_nxt  = running_sum_r;
    keep_payload_nxt = keep_payload_r;
    unique case (state_r)
      ST_HUNT: begin
        if (rx_byte == START_BYTE) state_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        if (rx_byte != 8'd0) begin
          if ({8'd0, rx_byte} < MAX_LEN_W) begin
            frame_length_nxt = {8'd0, rx_byte};
            bytes_seen_nxt   = 16'd0;
            running_sum_nxt  = 8'd0;
            state_nxt        = ST_DATA;
          end else begin
            state_nxt = ST_HUNT;
          end
        end else begin
          frame_length_nxt = 16'd0;
          state_nxt        = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        frame_length_nxt = lo_len;
        if (lo_len > MAX_LEN_W || lo_len == 16'd0) begin
          state_nxt = ST_HUNT;
        end else begin
          bytes_seen_nxt  = 16'd0;
          running_sum_nxt = 8'd0;
          state_nxt       = ST_DATA;
        end
      end
      ST_DATA: begin
        running_sum_nxt  = running_sum_r + rx_byte;
        keep_payload_nxt = keep_eff;
        bytes_seen_nxt   = seen_inc;
        if (seen_inc >= frame_length_r) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sum_ok && rx_byte == START_BYTE && !chunk_last) state_nxt = ST_RESYNC;
        else state_nxt = ST_HUNT;
      end
      ST_RESYNC: begin
        if (rx_byte == 8'd0) begin
          frame_length_nxt = 16'd0;
          state_nxt        = ST_LEN_LO;
        end else if (rx_byte == START_BYTE) begin
          state_nxt = ST_LEN_HI;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res.kind  = KIND_PAYLOAD;
    res.data  = 8'd0;
    unique case (state_r)
      ST_DATA: begin
        res_valid = keep_eff;
        res.data  = rx_byte;
      end
      ST_CHECK: begin
        res_valid = 1'b1;
        res.kind  = sum_ok ? KIND_GOOD : KIND_BAD;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_HUNT;
      frame_length_r <= 16'd0;
      bytes_seen_r   <= 16'd0;
      running_sum_r  <= 8'd0;
      keep_payload_r <= 1'b0;
    end else if (step) begin
      state_r        <= state_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      running_sum_r  <= running_sum_nxt;
      keep_payload_r <= keep_payload_nxt;
    end
  end

  a_res_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r == ST_DATA || state_r == ST_CHECK))
    else $error("result outside data or check state");

  a_seen_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> (bytes_seen_r < frame_length_r))
    else $error("byte count reached length while in data state");

  a_check_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (step && state_r == ST_CHECK) |=> (state_r == ST_HUNT || state_r == ST_RESYNC))
    else $error("check state did not return to hunt or resync");

endmodule

FILE: design/afr_out_reg.sv
module afr_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  afr_pkg::result_t res,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte
);
  import afr_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_kind  = data_r.kind;
  assign out_byte  = data_r.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) data_r <= res;
  end

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ready)
    else $error("result loaded while output register held");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.kind == KIND_PAYLOAD || data_r.kind == KIND_GOOD ||
                 data_r.kind == KIND_BAD))
    else $error("illegal result kind");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.kind != KIND_PAYLOAD) |-> (data_r.data == 8'd0))
    else $error("status result carries nonzero byte");

endmodule

FILE: design/api_frame_receiver.sv
// An accepted byte is registered at the input, then its result in the out_ register.
// Throughput: one byte per cycle unless stalled; parser state advances once per byte.
// A stalled output holds the result register and backs up through the input register.
// Reset (rst_n low, synchronous) returns the parser to hunt for the start byte
// and empties the input and output registers.
module api_frame_receiver #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_chunk_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte
);
  import afr_pkg::*;

  logic       full_r;
  logic [7:0] rx_byte_r;
  logic       chunk_last_r;
  logic       step;
  logic       res_valid;
  logic       out_ready;
  result_t    res;

  assign step     = full_r && out_ready;
  assign in_stall = full_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (!in_stall) begin
      full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      rx_byte_r    <= in_rx_byte;
      chunk_last_r <= in_chunk_last;
    end
  end

  afr_parser #(
    .MAX_LEN(MAX_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (rx_byte_r),
    .chunk_last(chunk_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  afr_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && res_valid),
    .res      (res),
    .ready    (out_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind (out_kind),
    .out_byte (out_byte)
  );

endmodule
